[sv/asc_pkg.sv]
package asc_pkg;

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_ENC_SAMPLE = 2'd0;
    localparam logic [1:0] OP_ENC_BUTTON = 2'd1;
    localparam logic [1:0] OP_PAD_BYTE   = 2'd2;
    localparam logic [1:0] OP_TIME_TICK  = 2'd3;

    localparam logic [4:0] HOUR_MAX     = 5'd23;
    localparam logic [5:0] MINUTE_MAX   = 6'd59;
    localparam logic [6:0] VOLUME_MAX   = 7'd100;
    localparam logic [6:0] VOLUME_RESET = 7'd50;

    localparam logic [7:0] START_BYTE = 8'h21;
    localparam logic [7:0] KIND_BYTE  = 8'h42;
    localparam logic [7:0] HIT_BYTE   = 8'h31;
    localparam logic [7:0] BTN_ENABLE = 8'h31;
    localparam logic [7:0] BTN_LIGHT  = 8'h32;
    localparam logic [7:0] BTN_UP     = 8'h35;
    localparam logic [7:0] BTN_DOWN   = 8'h36;
    localparam logic [7:0] BTN_PREV   = 8'h37;
    localparam logic [7:0] BTN_NEXT   = 8'h38;

    localparam logic [1:0] MENU_MINUTE = 2'd1;
    localparam logic [1:0] MENU_HOUR   = 2'd2;
    localparam logic [1:0] MENU_VOLUME = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] enc_ab;
        logic [7:0] pad_byte;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic       toggle_held;
    } t_in_item;

    typedef struct packed {
        logic [4:0] set_hour;
        logic [5:0] set_minute;
        logic [6:0] set_volume;
        logic [1:0] menu_item;
        logic       enabled;
        logic       matched;
        logic       sounding;
        logic       light_request;
        logic       frame_bad;
    } t_out_item;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_STEP_UP,
        CMD_STEP_DOWN,
        CMD_MENU_NEXT,
        CMD_MENU_PREV,
        CMD_TOGGLE,
        CMD_LIGHT,
        CMD_BAD_FRAME,
        CMD_TICK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic       toggle_held;
    } t_cmd;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_KIND   = 5'b00010,
        PH_BUTTON = 5'b00100,
        PH_HIT    = 5'b01000,
        PH_CHECK  = 5'b10000
    } t_phase;

    // quadrature transition table, indexed by {prev_ab, ab}
    function automatic t_cmd_kind enc_step(input logic [3:0] idx);
        t_cmd_kind k;
        begin
            unique case (idx)
                4'b0001, 4'b1101: k = CMD_STEP_UP;
                4'b0010, 4'b1110: k = CMD_STEP_DOWN;
                default:          k = CMD_NOP;
            endcase
            return k;
        end
    endfunction

    function automatic t_cmd_kind pad_action(input logic [7:0] button);
        t_cmd_kind k;
        begin
            unique case (button)
                BTN_ENABLE: k = CMD_TOGGLE;
                BTN_LIGHT:  k = CMD_LIGHT;
                BTN_UP:     k = CMD_STEP_UP;
                BTN_DOWN:   k = CMD_STEP_DOWN;
                BTN_PREV:   k = CMD_MENU_PREV;
                BTN_NEXT:   k = CMD_MENU_NEXT;
                default:    k = CMD_NOP;
            endcase
            return k;
        end
    endfunction

endpackage

[sv/asc_fifo.sv]
module asc_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/asc_front.sv]
module asc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  asc_pkg::t_in_item i_item,
    output asc_pkg::t_cmd     o_cmd
);
    import asc_pkg::*;

    t_phase     r_phase, n_phase;
    logic [1:0] r_prev_ab, n_prev_ab;
    logic [7:0] r_button, n_button;
    logic [7:0] r_hit, n_hit;
    logic [7:0] csum;

    assign csum = ~(START_BYTE + KIND_BYTE + r_button + r_hit);

    always_comb begin
        n_phase          = r_phase;
        n_prev_ab        = r_prev_ab;
        n_button         = r_button;
        n_hit            = r_hit;
        o_cmd.kind       = CMD_NOP;
        o_cmd.now_hour   = i_item.now_hour;
        o_cmd.now_minute = i_item.now_minute;
        o_cmd.toggle_held = i_item.toggle_held;
        case (i_item.opcode)
            OP_ENC_SAMPLE: begin
                o_cmd.kind = enc_step({r_prev_ab, i_item.enc_ab});
                n_prev_ab  = i_item.enc_ab;
            end
            OP_ENC_BUTTON: o_cmd.kind = CMD_MENU_NEXT;
            OP_PAD_BYTE: begin
                unique case (r_phase)
                    PH_KIND:   n_phase = (i_item.pad_byte == KIND_BYTE) ? PH_BUTTON : PH_START;
                    PH_BUTTON: begin
                        n_button = i_item.pad_byte;
                        n_phase  = PH_HIT;
                    end
                    PH_HIT: begin
                        n_hit   = i_item.pad_byte;
                        n_phase = PH_CHECK;
                    end
                    PH_CHECK: begin
                        n_phase = PH_START;
                        if (i_item.pad_byte != csum) begin
                            o_cmd.kind = CMD_BAD_FRAME;
                        end else if (r_hit == HIT_BYTE) begin
                            o_cmd.kind = pad_action(r_button);
                        end
                    end
                    default:   n_phase = (i_item.pad_byte == START_BYTE) ? PH_KIND : PH_START;
                endcase
            end
            default: o_cmd.kind = CMD_TICK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_prev_ab <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_prev_ab <= n_prev_ab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_button <= n_button;
            r_hit    <= n_hit;
        end
    end

endmodule

[sv/asc_back.sv]
module asc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  asc_pkg::t_cmd      i_cmd,
    output asc_pkg::t_out_item o_result
);
    import asc_pkg::*;

    logic [4:0] r_hour, n_hour;
    logic [5:0] r_minute, n_minute;
    logic [6:0] r_volume, n_volume;
    logic [1:0] r_menu, n_menu;
    logic       r_enable, n_enable;
    logic       r_match, n_match;
    logic       light, bad;
    logic       step_up, step_down;

    assign step_up   = (i_cmd.kind == CMD_STEP_UP);
    assign step_down = (i_cmd.kind == CMD_STEP_DOWN);

    always_comb begin
        n_hour   = r_hour;
        n_minute = r_minute;
        n_volume = r_volume;
        n_menu   = r_menu;
        n_enable = r_enable;
        n_match  = r_match;
        light    = 1'b0;
        bad      = 1'b0;
        if (step_up || step_down) begin
            case (r_menu)
                MENU_MINUTE: begin
                    if (step_up) n_minute = (r_minute >= MINUTE_MAX) ? '0 : r_minute + 1'b1;
                    else         n_minute = (r_minute == '0) ? MINUTE_MAX : r_minute - 1'b1;
                end
                MENU_HOUR: begin
                    if (step_up) n_hour = (r_hour >= HOUR_MAX) ? '0 : r_hour + 1'b1;
                    else         n_hour = (r_hour == '0) ? HOUR_MAX : r_hour - 1'b1;
                end
                MENU_VOLUME: begin
                    if (step_up && r_volume < VOLUME_MAX) n_volume = r_volume + 1'b1;
                    else if (step_down && r_volume != '0) n_volume = r_volume - 1'b1;
                end
                default: ;
            endcase
        end
        case (i_cmd.kind)
            CMD_MENU_NEXT: n_menu = r_menu + 1'b1;
            CMD_MENU_PREV: n_menu = r_menu - 1'b1;
            CMD_TOGGLE:    n_enable = ~r_enable;
            CMD_LIGHT:     light = 1'b1;
            CMD_BAD_FRAME: bad = 1'b1;
            CMD_TICK: begin
                n_match = (r_hour == i_cmd.now_hour) && (r_minute == i_cmd.now_minute);
                if (i_cmd.toggle_held) n_enable = ~r_enable;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.set_hour      = n_hour;
        o_result.set_minute    = n_minute;
        o_result.set_volume    = n_volume;
        o_result.menu_item     = n_menu;
        o_result.enabled       = n_enable;
        o_result.matched       = n_match;
        o_result.sounding      = n_enable & n_match;
        o_result.light_request = light;
        o_result.frame_bad     = bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour   <= '0;
            r_minute <= '0;
            r_volume <= VOLUME_RESET;
            r_menu   <= '0;
            r_enable <= 1'b1;
            r_match  <= 1'b0;
        end else if (i_fire) begin
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_volume <= n_volume;
            r_menu   <= n_menu;
            r_enable <= n_enable;
            r_match  <= n_match;
        end
    end

endmodule

[sv/alarm_setting_controller.sv]
// Channel    Direction  Handshake            Payload
// input      in         push / full          i_item   (t_in_item)
// result     out        empty / pop          o_result (t_out_item)
//
// One request per cycle sustained while full is low; each is registered first in
// the command queue (front decode), then in the result queue (back update).
// Reset clears both queues and loads the alarm state (volume 50, enable set).
// full rises only once the command queue backs up behind a full result queue.
module alarm_setting_controller #(
    parameter int CMD_DEPTH = asc_pkg::CMD_QUEUE_DEPTH,
    parameter int RES_DEPTH = asc_pkg::RES_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  asc_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output asc_pkg::t_out_item o_result
);
    import asc_pkg::*;

    t_cmd      front_cmd, back_cmd;
    t_out_item back_result;
    logic      take;
    logic      cmd_empty;
    logic      res_full;
    logic      fire;

    assign take = push && !full;
    assign fire = !cmd_empty && !res_full;

    asc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_item),
        .o_cmd   (front_cmd)
    );

    asc_fifo #(.T(t_cmd), .DEPTH(CMD_DEPTH)) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (fire),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    asc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (back_cmd),
        .o_result (back_result)
    );

    asc_fifo #(.T(t_out_item), .DEPTH(RES_DEPTH)) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (back_result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_sounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.sounding == (o_result.enabled && o_result.matched)))
        else $error("sounding disagrees with enabled and matched");

    a_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_result.light_request && o_result.frame_bad))
        else $error("light and bad frame pulses together");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.set_hour <= HOUR_MAX && o_result.set_minute <= MINUTE_MAX
                    && o_result.set_volume <= VOLUME_MAX))
        else $error("alarm setting out of range");

    a_first_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && empty && cmd_empty && !res_full) |=> !cmd_empty)
        else $error("accepted request missing from command queue");

endmodule
